>>> rtl/core/iir_pkg.sv
// ----------------------------------------------------------------------------
// iir_pkg
// Shared types and constants of the I/O interrupt router: command word that
// travels from the front end to the back end, result kinds, control word
// layout and register decode.
// ----------------------------------------------------------------------------
`default_nettype none

package iir_pkg;

   // number of pins that own a table entry (1 to 32)
   localparam int NUM_PINS = 32;

   // control word layout
   localparam int CTL_DSTAT_BIT = 12;
   localparam int CTL_SWINT_BIT = 13;
   localparam int CTL_TRIG_BIT  = 15;
   localparam int CTL_MASK_BIT  = 16;
   localparam logic [31:0] CTL_RESET = 32'h0001_0000;

   // message data and address low layout
   localparam int MSG_VEC_LSB  = 0;
   localparam int MSG_DLVM_LSB = 10;
   localparam int ADDR_DEST_LSB = 4;

   localparam logic [31:0] ALL_ONES = 32'hffff_ffff;

   // version from which eoi and software-int writes keep the read-write bits
   localparam logic [1:0] VERSION_KEEP_BITS = 2'd2;

   // request operation codes
   typedef enum logic [1:0] {
      OP_PIN   = 2'd0,
      OP_READ  = 2'd1,
      OP_WRITE = 2'd2,
      OP_IDLE  = 2'd3
   } op_type;

   // register select codes
   typedef enum logic [2:0] {
      SEL_ID      = 3'd0,
      SEL_VERSION = 3'd1,
      SEL_CONTROL = 3'd2,
      SEL_MESSAGE = 3'd3,
      SEL_ADDR_HI = 3'd4,
      SEL_ADDR_LO = 3'd5,
      SEL_REQ_ID  = 3'd6,
      SEL_UNKNOWN = 3'd7
   } sel_type;

   // resolved register target of an access
   typedef enum logic [2:0] {
      TG_ID   = 3'd0,
      TG_VER  = 3'd1,
      TG_CTL  = 3'd2,
      TG_MSG  = 3'd3,
      TG_AHI  = 3'd4,
      TG_ALO  = 3'd5,
      TG_ZERO = 3'd6,
      TG_ONES = 3'd7
   } target_type;

   // result kinds
   typedef enum logic [2:0] {
      RK_READ      = 3'd0,
      RK_DONE      = 3'd1,
      RK_SENT      = 3'd2,
      RK_COALESCED = 3'd3,
      RK_MASKED    = 3'd4
   } kind_type;

   // back end sequencer states
   typedef enum logic {
      BK_IDLE = 1'b0,
      BK_EXEC = 1'b1
   } back_state_type;

   // classified command word
   typedef struct packed {
      op_type      op;
      logic [4:0]  pin;
      logic        pin_ok;
      logic        level;
      target_type  tgt;
      logic [31:0] data;
   } cmd_type;

endpackage

`default_nettype wire

>>> rtl/core/io_interrupt_router.sv
// ----------------------------------------------------------------------------
// io_interrupt_router
// I/O interrupt router with a per-pin redirection table and pending mask.
// ----------------------------------------------------------------------------
// Usage:
//   req_* channel carries one word per pin level change or register access;
//   it is taken at a clock edge with req_valid high and req_stall low.
//   rsp_* channel returns exactly one result word per request, in order,
//   taken at a clock edge with rsp_valid high and rsp_stall low.
//   csr_* channel writes the device version; csr_ready is always high; the
//   user writes only while no request is in flight, unchecked by the block.
// Flow:
//   a request is queued in a two-entry command queue; the back end pops it
//   into a register and reads its table entry in the IDLE state, then
//   applies it and loads the output register in the EXEC state, held while
//   the output stalls; it pops no new command until it has applied the last.
// Reset:
//   all entries masked, other table words zero, pending mask and id zero,
//   version 2; the block accepts words in the cycle after reset.
// Stall:
//   a stalled result holds in the output register; the queue keeps taking
//   words until it holds two, then req_stall rises.
// ----------------------------------------------------------------------------
`default_nettype none

module io_interrupt_router (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [1:0]  req_operation,
   input  wire logic [4:0]  req_pin_index,
   input  wire logic        req_pin_level,
   input  wire logic [2:0]  req_reg_select,
   input  wire logic [31:0] req_write_data,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [2:0]       rsp_result_kind,
   output logic [31:0]      rsp_read_data,
   output logic [15:0]      rsp_msg_dest,
   output logic [9:0]       rsp_msg_vector,
   output logic             rsp_msg_level_trigger,
   output logic [2:0]       rsp_msg_delivery_mode,
   output logic             rsp_ack_notify,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [1:0]  csr_write_data
);

   iir_pkg::cmd_type front_cmd;
   iir_pkg::cmd_type head_cmd;
   logic q_full, q_empty, q_pop, q_push;
   logic [1:0] device_version_ff;

   // version register
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         device_version_ff <= 2'd2;
      end else if (csr_valid && csr_ready) begin
         device_version_ff <= csr_write_data;
      end
   end

   // front end classification
   iir_front u_front (
      .req_operation  (req_operation),
      .req_pin_index  (req_pin_index),
      .req_pin_level  (req_pin_level),
      .req_reg_select (req_reg_select),
      .req_write_data (req_write_data),
      .cmd            (front_cmd)
   );

   // command queue
   assign req_stall = q_full;
   assign q_push    = req_valid && !q_full;

   iir_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_cmd (front_cmd),
      .full     (q_full),
      .pop      (q_pop),
      .head_cmd (head_cmd),
      .empty    (q_empty)
   );

   // back end execution
   iir_back u_back (
      .clock                 (clock),
      .reset                 (reset),
      .head_cmd              (head_cmd),
      .q_empty               (q_empty),
      .q_pop                 (q_pop),
      .device_version        (device_version_ff),
      .rsp_valid             (rsp_valid),
      .rsp_stall             (rsp_stall),
      .rsp_result_kind       (rsp_result_kind),
      .rsp_read_data         (rsp_read_data),
      .rsp_msg_dest          (rsp_msg_dest),
      .rsp_msg_vector        (rsp_msg_vector),
      .rsp_msg_level_trigger (rsp_msg_level_trigger),
      .rsp_msg_delivery_mode (rsp_msg_delivery_mode),
      .rsp_ack_notify        (rsp_ack_notify)
   );

endmodule

`default_nettype wire

>>> rtl/core/iir_front.sv
// ----------------------------------------------------------------------------
// iir_front
// Front end: classifies a request word into a command, resolving the
// register target and the pin range check.
// ----------------------------------------------------------------------------
`default_nettype none

module iir_front (
   input  wire logic [1:0]  req_operation,
   input  wire logic [4:0]  req_pin_index,
   input  wire logic        req_pin_level,
   input  wire logic [2:0]  req_reg_select,
   input  wire logic [31:0] req_write_data,
   output iir_pkg::cmd_type cmd
);

   logic pin_ok;

   // pin range check
   assign pin_ok = ({1'b0, req_pin_index} < 6'(iir_pkg::NUM_PINS));

   // register target decode; table registers of a missing pin read all ones
   always_comb begin
      cmd.op     = iir_pkg::op_type'(req_operation);
      cmd.pin    = req_pin_index;
      cmd.pin_ok = pin_ok;
      cmd.level  = req_pin_level;
      cmd.data   = req_write_data;
      case (iir_pkg::sel_type'(req_reg_select))
         iir_pkg::SEL_ID:      cmd.tgt = iir_pkg::TG_ID;
         iir_pkg::SEL_VERSION: cmd.tgt = iir_pkg::TG_VER;
         iir_pkg::SEL_CONTROL: cmd.tgt = pin_ok ? iir_pkg::TG_CTL : iir_pkg::TG_ONES;
         iir_pkg::SEL_MESSAGE: cmd.tgt = pin_ok ? iir_pkg::TG_MSG : iir_pkg::TG_ONES;
         iir_pkg::SEL_ADDR_HI: cmd.tgt = pin_ok ? iir_pkg::TG_AHI : iir_pkg::TG_ONES;
         iir_pkg::SEL_ADDR_LO: cmd.tgt = pin_ok ? iir_pkg::TG_ALO : iir_pkg::TG_ONES;
         iir_pkg::SEL_REQ_ID:  cmd.tgt = iir_pkg::TG_ZERO;
         default:              cmd.tgt = iir_pkg::TG_ONES;
      endcase
   end

endmodule

`default_nettype wire

>>> rtl/core/iir_queue.sv
// ----------------------------------------------------------------------------
// iir_queue
// Two-entry command queue between the front end and the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module iir_queue (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        push,
   input  wire iir_pkg::cmd_type push_cmd,
   output logic             full,
   input  wire logic        pop,
   output iir_pkg::cmd_type head_cmd,
   output logic             empty
);

   iir_pkg::cmd_type slot_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;

   assign full     = (count_ff == 2'd2);
   assign empty    = (count_ff == 2'd0);
   assign head_cmd = slot_ff[rd_ptr_ff];

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      pop |-> !empty) else $error("queue popped while empty");
   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      push |-> !full) else $error("queue pushed while full");
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff != 2'd3) else $error("queue count out of range");

endmodule

`default_nettype wire

>>> rtl/core/iir_back.sv
// ----------------------------------------------------------------------------
// iir_back
// Back end: reads the redirection table entry of a command, applies the
// pin change or register access, writes the entry back and loads the
// result word into the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module iir_back (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire iir_pkg::cmd_type head_cmd,
   input  wire logic        q_empty,
   output logic             q_pop,
   input  wire logic [1:0]  device_version,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [2:0]       rsp_result_kind,
   output logic [31:0]      rsp_read_data,
   output logic [15:0]      rsp_msg_dest,
   output logic [9:0]       rsp_msg_vector,
   output logic             rsp_msg_level_trigger,
   output logic [2:0]       rsp_msg_delivery_mode,
   output logic             rsp_ack_notify
);

   // redirection table and per-entry written flags
   logic [31:0] ctl_mem [32];
   logic [31:0] msg_mem [32];
   logic [31:0] ahi_mem [32];
   logic [31:0] alo_mem [32];
   logic [31:0] ctl_vld_ff, msg_vld_ff, ahi_vld_ff, alo_vld_ff;

   logic [31:0] ctl_rd_ff, msg_rd_ff, ahi_rd_ff, alo_rd_ff;
   logic        ctl_rv_ff, msg_rv_ff, ahi_rv_ff, alo_rv_ff;

   iir_pkg::back_state_type state_ff, state_in;
   iir_pkg::cmd_type        cmd_ff;
   logic [31:0] pending_ff, pending_in;
   logic [31:0] device_id_ff, device_id_in;

   logic rsp_valid_ff, rsp_valid_in;
   logic [2:0]  kind_ff;
   logic [31:0] rdata_ff;
   logic [15:0] dest_ff;
   logic [9:0]  vec_ff;
   logic        trig_ff;
   logic [2:0]  dlvm_ff;
   logic        ack_ff;

   logic out_free;
   logic exec_en;

   logic [31:0] ctl_cur, msg_cur, ahi_cur, alo_cur;
   logic        eoi, sint;
   logic [31:0] ctl_base, ctl_new;

   iir_pkg::kind_type kind_in;
   logic [31:0] rdata_in;
   logic [15:0] dest_in;
   logic [9:0]  vec_in;
   logic        trig_in;
   logic [2:0]  dlvm_in;
   logic        ack_in;
   logic        fire_req;
   logic [31:0] fire_ctl;
   logic        ctl_we, msg_we, ahi_we, alo_we;
   logic [31:0] ctl_wd;

   assign out_free = !rsp_valid_ff || !rsp_stall;

   // sequencer next state
   always_comb begin
      case (state_ff)
         iir_pkg::BK_IDLE: state_in = q_empty ? iir_pkg::BK_IDLE : iir_pkg::BK_EXEC;
         iir_pkg::BK_EXEC: state_in = out_free ? iir_pkg::BK_IDLE : iir_pkg::BK_EXEC;
         default:          state_in = iir_pkg::BK_IDLE;
      endcase
   end

   // sequencer outputs
   always_comb begin
      case (state_ff)
         iir_pkg::BK_IDLE: begin
            q_pop   = !q_empty;
            exec_en = 1'b0;
         end
         iir_pkg::BK_EXEC: begin
            q_pop   = 1'b0;
            exec_en = out_free;
         end
         default: begin
            q_pop   = 1'b0;
            exec_en = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= iir_pkg::BK_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // command latch and table read on pop
   always_ff @(posedge clock) begin
      if (q_pop) begin
         cmd_ff    <= head_cmd;
         ctl_rd_ff <= ctl_mem[head_cmd.pin];
         msg_rd_ff <= msg_mem[head_cmd.pin];
         ahi_rd_ff <= ahi_mem[head_cmd.pin];
         alo_rd_ff <= alo_mem[head_cmd.pin];
         ctl_rv_ff <= ctl_vld_ff[head_cmd.pin];
         msg_rv_ff <= msg_vld_ff[head_cmd.pin];
         ahi_rv_ff <= ahi_vld_ff[head_cmd.pin];
         alo_rv_ff <= alo_vld_ff[head_cmd.pin];
      end
   end

   // entries never written read as their reset value
   assign ctl_cur = ctl_rv_ff ? ctl_rd_ff : iir_pkg::CTL_RESET;
   assign msg_cur = msg_rv_ff ? msg_rd_ff : '0;
   assign ahi_cur = ahi_rv_ff ? ahi_rd_ff : '0;
   assign alo_cur = alo_rv_ff ? alo_rd_ff : '0;

   // control write value: eoi and software-int bits clear, newer version keeps the rest
   always_comb begin
      eoi      = cmd_ff.data[iir_pkg::CTL_DSTAT_BIT];
      sint     = cmd_ff.data[iir_pkg::CTL_SWINT_BIT];
      ctl_base = ((device_version >= iir_pkg::VERSION_KEEP_BITS) && (eoi || sint))
                 ? ctl_cur : cmd_ff.data;
      ctl_new  = ctl_base;
      if (eoi) begin
         ctl_new[iir_pkg::CTL_DSTAT_BIT] = 1'b0;
      end
      if (sint) begin
         ctl_new[iir_pkg::CTL_SWINT_BIT] = 1'b0;
      end
   end

   // command execution
   always_comb begin
      kind_in      = iir_pkg::RK_DONE;
      rdata_in     = '0;
      dest_in      = '0;
      vec_in       = '0;
      trig_in      = 1'b0;
      dlvm_in      = '0;
      ack_in       = 1'b0;
      fire_req     = 1'b0;
      fire_ctl     = ctl_cur;
      pending_in   = pending_ff;
      device_id_in = device_id_ff;
      ctl_we       = 1'b0;
      ctl_wd       = ctl_cur;
      msg_we       = 1'b0;
      ahi_we       = 1'b0;
      alo_we       = 1'b0;
      case (cmd_ff.op)
         iir_pkg::OP_PIN: begin
            if (cmd_ff.pin_ok) begin
               pending_in[cmd_ff.pin] = cmd_ff.level;
               if (cmd_ff.level) begin
                  if ((!ctl_cur[iir_pkg::CTL_TRIG_BIT] && !pending_ff[cmd_ff.pin]) ||
                      (ctl_cur[iir_pkg::CTL_TRIG_BIT] && !ctl_cur[iir_pkg::CTL_DSTAT_BIT]))
                  begin
                     fire_req = 1'b1;
                  end else begin
                     kind_in = iir_pkg::RK_COALESCED;
                  end
               end
            end
         end
         iir_pkg::OP_READ: begin
            kind_in = iir_pkg::RK_READ;
            case (cmd_ff.tgt)
               iir_pkg::TG_ID:   rdata_in = device_id_ff;
               iir_pkg::TG_VER:  rdata_in = {8'd0, 8'(iir_pkg::NUM_PINS), 14'd0, device_version};
               iir_pkg::TG_CTL:  rdata_in = ctl_cur;
               iir_pkg::TG_MSG:  rdata_in = msg_cur;
               iir_pkg::TG_AHI:  rdata_in = ahi_cur;
               iir_pkg::TG_ALO:  rdata_in = alo_cur;
               iir_pkg::TG_ZERO: rdata_in = '0;
               default:          rdata_in = iir_pkg::ALL_ONES;
            endcase
         end
         iir_pkg::OP_WRITE: begin
            case (cmd_ff.tgt)
               iir_pkg::TG_ID:  device_id_in = cmd_ff.data;
               iir_pkg::TG_CTL: begin
                  ack_in   = eoi;
                  ctl_we   = 1'b1;
                  ctl_wd   = ctl_new;
                  fire_ctl = ctl_new;
                  fire_req = !ctl_new[iir_pkg::CTL_MASK_BIT] && pending_ff[cmd_ff.pin];
               end
               iir_pkg::TG_MSG: msg_we = 1'b1;
               iir_pkg::TG_AHI: ahi_we = 1'b1;
               iir_pkg::TG_ALO: alo_we = 1'b1;
               default: ;
            endcase
         end
         default: ;
      endcase

      // message delivery
      if (fire_req) begin
         if (fire_ctl[iir_pkg::CTL_MASK_BIT]) begin
            kind_in = iir_pkg::RK_MASKED;
         end else begin
            kind_in = iir_pkg::RK_SENT;
            dest_in = alo_cur[iir_pkg::ADDR_DEST_LSB +: 16];
            vec_in  = msg_cur[iir_pkg::MSG_VEC_LSB +: 10];
            dlvm_in = msg_cur[iir_pkg::MSG_DLVM_LSB +: 3];
            trig_in = fire_ctl[iir_pkg::CTL_TRIG_BIT];
            if (fire_ctl[iir_pkg::CTL_TRIG_BIT]) begin
               ctl_we = 1'b1;
               ctl_wd = fire_ctl;
               ctl_wd[iir_pkg::CTL_DSTAT_BIT] = 1'b1;
            end
         end
      end
   end

   // table write back
   always_ff @(posedge clock) begin
      if (exec_en && ctl_we) begin
         ctl_mem[cmd_ff.pin] <= ctl_wd;
      end
      if (exec_en && msg_we) begin
         msg_mem[cmd_ff.pin] <= cmd_ff.data;
      end
      if (exec_en && ahi_we) begin
         ahi_mem[cmd_ff.pin] <= cmd_ff.data;
      end
      if (exec_en && alo_we) begin
         alo_mem[cmd_ff.pin] <= cmd_ff.data;
      end
   end

   // written flags, pending mask and id register
   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_vld_ff   <= '0;
         msg_vld_ff   <= '0;
         ahi_vld_ff   <= '0;
         alo_vld_ff   <= '0;
         pending_ff   <= '0;
         device_id_ff <= '0;
      end else if (exec_en) begin
         if (ctl_we) begin
            ctl_vld_ff[cmd_ff.pin] <= 1'b1;
         end
         if (msg_we) begin
            msg_vld_ff[cmd_ff.pin] <= 1'b1;
         end
         if (ahi_we) begin
            ahi_vld_ff[cmd_ff.pin] <= 1'b1;
         end
         if (alo_we) begin
            alo_vld_ff[cmd_ff.pin] <= 1'b1;
         end
         pending_ff   <= pending_in;
         device_id_ff <= device_id_in;
      end
   end

   // output register
   assign rsp_valid_in = exec_en || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (exec_en) begin
         kind_ff  <= kind_in;
         rdata_ff <= rdata_in;
         dest_ff  <= dest_in;
         vec_ff   <= vec_in;
         trig_ff  <= trig_in;
         dlvm_ff  <= dlvm_in;
         ack_ff   <= ack_in;
      end
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_result_kind       = kind_ff;
   assign rsp_read_data         = rdata_ff;
   assign rsp_msg_dest          = dest_ff;
   assign rsp_msg_vector        = vec_ff;
   assign rsp_msg_level_trigger = trig_ff;
   assign rsp_msg_delivery_mode = dlvm_ff;
   assign rsp_ack_notify        = ack_ff;

   a_rsp_from_exec: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == iir_pkg::BK_EXEC))
      else $error("result word without execution");
   a_ack_on_write: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && ack_ff) |->
         (kind_ff == iir_pkg::RK_DONE || kind_ff == iir_pkg::RK_SENT))
      else $error("eoi acknowledge with wrong result kind");
   a_msg_only_sent: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && kind_ff != iir_pkg::RK_SENT) |->
         (dest_ff == '0 && vec_ff == '0 && !trig_ff && dlvm_ff == '0))
      else $error("message fields set without a message");

endmodule

`default_nettype wire
